// ===== sv/pssl_pkg.sv =====
`default_nettype none
package pssl_pkg;

   // pool size and derived widths
   localparam int SLOT_COUNT = 64;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   // field widths fixed by the interface
   localparam int OP_W   = 2;
   localparam int SLOT_W = 6;
   localparam int HALF_W = 16;
   localparam int KEY_W  = 2 * HALF_W;
   localparam int STAT_W = 3;

   // links carry one extra bit so that null sits outside the slot range
   localparam int LINK_W = SLOT_W + 1;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_REKEY   = 2'd2,
      OP_WALK    = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_IGNORED    = 3'd2,
      STAT_EMPTY      = 3'd3,
      STAT_BAD_HANDLE = 3'd4
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [SLOT_W-1:0] slot_handle;
      logic [HALF_W-1:0] major_key;
      logic [HALF_W-1:0] minor_key;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] result_slot;
      logic              last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ALLOC,
      ST_UNLINK,
      ST_INS_START,
      ST_INS_STEP,
      ST_INS_FIX,
      ST_INS_TAIL,
      ST_RESP,
      ST_WALK
   } state_type;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LATCH,
      CMD_DECODE,
      CMD_ALLOC,
      CMD_UNLINK,
      CMD_INS_START,
      CMD_INS_STEP,
      CMD_INS_FIX,
      CMD_INS_TAIL,
      CMD_RESP,
      CMD_WALK
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       early_done;
      logic       list_empty;
      logic       key_less;
      logic       at_tail;
      logic       walk_last;
      logic       out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== sv/pssl_ram.sv =====
`default_nettype none
module pssl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/pssl_ctrl.sv =====
`default_nettype none
module pssl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire pssl_pkg::dp_status_type sts,
   output pssl_pkg::cmd_type           cmd
);

   pssl_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pssl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pssl_pkg::ST_IDLE: begin
            if (req_valid) state_in = pssl_pkg::ST_DECODE;
         end
         pssl_pkg::ST_DECODE: begin
            if (sts.early_done) begin
               state_in = pssl_pkg::ST_RESP;
            end else begin
               case (sts.op)
                  pssl_pkg::OP_ALLOC:   state_in = pssl_pkg::ST_ALLOC;
                  pssl_pkg::OP_RELEASE: state_in = pssl_pkg::ST_UNLINK;
                  pssl_pkg::OP_REKEY:   state_in = pssl_pkg::ST_UNLINK;
                  pssl_pkg::OP_WALK:    state_in = pssl_pkg::ST_WALK;
                  default:              state_in = pssl_pkg::ST_RESP;
               endcase
            end
         end
         pssl_pkg::ST_ALLOC: state_in = pssl_pkg::ST_INS_START;
         pssl_pkg::ST_UNLINK: begin
            if (sts.op == pssl_pkg::OP_REKEY) state_in = pssl_pkg::ST_INS_START;
            else state_in = pssl_pkg::ST_RESP;
         end
         pssl_pkg::ST_INS_START: begin
            if (sts.list_empty) state_in = pssl_pkg::ST_RESP;
            else state_in = pssl_pkg::ST_INS_STEP;
         end
         pssl_pkg::ST_INS_STEP: begin
            if (sts.key_less) state_in = pssl_pkg::ST_INS_FIX;
            else if (sts.at_tail) state_in = pssl_pkg::ST_INS_TAIL;
         end
         pssl_pkg::ST_INS_FIX:  state_in = pssl_pkg::ST_RESP;
         pssl_pkg::ST_INS_TAIL: state_in = pssl_pkg::ST_RESP;
         pssl_pkg::ST_RESP: begin
            if (sts.out_free) state_in = pssl_pkg::ST_IDLE;
         end
         pssl_pkg::ST_WALK: begin
            if (sts.out_free && sts.walk_last) state_in = pssl_pkg::ST_IDLE;
         end
         default: state_in = pssl_pkg::ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      req_ready = 1'b0;
      cmd.code  = pssl_pkg::CMD_IDLE;
      case (state_ff)
         pssl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.code = pssl_pkg::CMD_LATCH;
         end
         pssl_pkg::ST_DECODE:    cmd.code = pssl_pkg::CMD_DECODE;
         pssl_pkg::ST_ALLOC:     cmd.code = pssl_pkg::CMD_ALLOC;
         pssl_pkg::ST_UNLINK:    cmd.code = pssl_pkg::CMD_UNLINK;
         pssl_pkg::ST_INS_START: cmd.code = pssl_pkg::CMD_INS_START;
         pssl_pkg::ST_INS_STEP:  cmd.code = pssl_pkg::CMD_INS_STEP;
         pssl_pkg::ST_INS_FIX:   cmd.code = pssl_pkg::CMD_INS_FIX;
         pssl_pkg::ST_INS_TAIL:  cmd.code = pssl_pkg::CMD_INS_TAIL;
         pssl_pkg::ST_RESP:      cmd.code = pssl_pkg::CMD_RESP;
         pssl_pkg::ST_WALK:      cmd.code = pssl_pkg::CMD_WALK;
         default:                cmd.code = pssl_pkg::CMD_IDLE;
      endcase
   end

   // a single result waits until the output register frees up
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pssl_pkg::ST_RESP && !sts.out_free) |=> state_ff == pssl_pkg::ST_RESP)
      else $error("result dropped while output busy");

   // walk ends right after its final result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pssl_pkg::ST_WALK && sts.out_free && sts.walk_last)
      |=> state_ff == pssl_pkg::ST_IDLE)
      else $error("walk did not finish on last slot");

   // a new transaction always starts with decode
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == pssl_pkg::ST_DECODE)
      else $error("accepted transaction not decoded");

endmodule
`default_nettype wire

// ===== sv/pssl_dp.sv =====
`default_nettype none
module pssl_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pssl_pkg::cmd_type       cmd,
   output pssl_pkg::dp_status_type      sts,
   input  wire pssl_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output pssl_pkg::rsp_type            rsp_data
);

   localparam int IW = pssl_pkg::IDX_W;
   localparam int LW = pssl_pkg::LINK_W;
   localparam int CW = pssl_pkg::CNT_W;
   localparam int SW = pssl_pkg::SLOT_W;
   localparam int KW = pssl_pkg::KEY_W;
   localparam int HW = pssl_pkg::HALF_W;

   // transaction registers
   pssl_pkg::opcode_type op_ff, op_in;
   logic [SW-1:0] h_ff, h_in;
   logic [KW-1:0] key_ff, key_in;
   logic [LW-1:0] s_ff, s_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] sm_ff, sm_in;
   logic [pssl_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic [SW-1:0] res_slot_ff, res_slot_in;

   // list control state
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] smallest_ff, smallest_in;
   logic [pssl_pkg::SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [pssl_pkg::SLOT_COUNT-1:0] fs_valid_ff, fs_valid_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   pssl_pkg::rsp_type rsp_ff, rsp_in;

   // memory ports
   logic [IW-1:0] rd_addr;
   logic [KW-1:0] keys_rdata;
   logic [LW-1:0] lgr_rdata, sml_rdata;
   logic [SW-1:0] fstk_rdata;
   logic keys_we, lgr_we, sml_we, fstk_we;
   logic [IW-1:0] keys_waddr, lgr_waddr, sml_waddr, fstk_waddr;
   logic [KW-1:0] keys_wdata;
   logic [LW-1:0] lgr_wdata, sml_wdata;
   logic [SW-1:0] fstk_wdata;

   // decode helpers
   logic          full;
   logic          h_ok;
   logic          list_empty;
   logic          out_free;
   logic [pssl_pkg::STAT_W-1:0] dec_status;
   logic          dec_err;
   logic [SW-1:0] popped;
   logic [CW-1:0] count_dec;

   assign full       = (count_ff == CW'(pssl_pkg::SLOT_COUNT));
   assign h_ok       = ({1'b0, h_ff} < (SW + 1)'(pssl_pkg::SLOT_COUNT)) && in_use_ff[h_ff[IW-1:0]];
   assign list_empty = (smallest_ff == pssl_pkg::NIL);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign popped     = fs_valid_ff[count_ff[IW-1:0]] ? fstk_rdata : SW'(count_ff);
   assign count_dec  = count_ff - CW'(1);

   // error checks ahead of any list work
   always_comb begin
      dec_status = pssl_pkg::STAT_OK;
      case (op_ff)
         pssl_pkg::OP_ALLOC: begin
            if (full) dec_status = pssl_pkg::STAT_FULL;
         end
         pssl_pkg::OP_RELEASE: begin
            if (count_ff == '0) dec_status = pssl_pkg::STAT_IGNORED;
            else if (!h_ok) dec_status = pssl_pkg::STAT_BAD_HANDLE;
         end
         pssl_pkg::OP_REKEY: begin
            if (!h_ok) dec_status = pssl_pkg::STAT_BAD_HANDLE;
         end
         pssl_pkg::OP_WALK: begin
            if (list_empty) dec_status = pssl_pkg::STAT_EMPTY;
         end
         default: dec_status = pssl_pkg::STAT_OK;
      endcase
   end
   assign dec_err = (dec_status != pssl_pkg::STAT_OK);

   // status to the controller
   always_comb begin
      sts.op         = op_ff;
      sts.early_done = dec_err;
      sts.list_empty = list_empty;
      sts.key_less   = (key_ff < keys_rdata);
      sts.at_tail    = (lgr_rdata == pssl_pkg::NIL);
      sts.walk_last  = (lgr_rdata == pssl_pkg::NIL);
      sts.out_free   = out_free;
   end

   // shared read address for key and link memories
   always_comb begin
      case (cmd.code)
         pssl_pkg::CMD_DECODE: begin
            if (op_ff == pssl_pkg::OP_WALK) rd_addr = smallest_ff[IW-1:0];
            else rd_addr = h_ff[IW-1:0];
         end
         pssl_pkg::CMD_INS_START: rd_addr = smallest_ff[IW-1:0];
         pssl_pkg::CMD_INS_STEP:  rd_addr = lgr_rdata[IW-1:0];
         pssl_pkg::CMD_WALK:      rd_addr = out_free ? lgr_rdata[IW-1:0] : cur_ff[IW-1:0];
         default:                 rd_addr = cur_ff[IW-1:0];
      endcase
   end

   // datapath actions per command
   always_comb begin
      op_in         = op_ff;
      h_in          = h_ff;
      key_in        = key_ff;
      s_in          = s_ff;
      cur_in        = cur_ff;
      sm_in         = sm_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      count_in      = count_ff;
      smallest_in   = smallest_ff;
      in_use_in     = in_use_ff;
      fs_valid_in   = fs_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      keys_we       = 1'b0;
      keys_waddr    = s_ff[IW-1:0];
      keys_wdata    = key_ff;
      lgr_we        = 1'b0;
      lgr_waddr     = s_ff[IW-1:0];
      lgr_wdata     = pssl_pkg::NIL;
      sml_we        = 1'b0;
      sml_waddr     = s_ff[IW-1:0];
      sml_wdata     = pssl_pkg::NIL;
      fstk_we       = 1'b0;
      fstk_waddr    = count_dec[IW-1:0];
      fstk_wdata    = s_ff[SW-1:0];
      case (cmd.code)
         pssl_pkg::CMD_LATCH: begin
            op_in  = pssl_pkg::opcode_type'(req_data.opcode);
            h_in   = req_data.slot_handle;
            key_in = {req_data.major_key, req_data.minor_key};
         end
         pssl_pkg::CMD_DECODE: begin
            res_status_in = dec_status;
            res_slot_in   = '0;
            s_in          = {1'b0, h_ff};
            cur_in        = smallest_ff;
         end
         pssl_pkg::CMD_ALLOC: begin
            s_in                 = {1'b0, popped};
            res_slot_in          = popped;
            count_in             = count_ff + CW'(1);
            in_use_in[popped[IW-1:0]] = 1'b1;
            keys_we              = 1'b1;
            keys_waddr           = popped[IW-1:0];
            keys_wdata           = key_ff;
         end
         pssl_pkg::CMD_UNLINK: begin
            // bridge the neighbors around the slot
            if (sml_rdata != pssl_pkg::NIL) begin
               lgr_we    = 1'b1;
               lgr_waddr = sml_rdata[IW-1:0];
               lgr_wdata = lgr_rdata;
            end else begin
               smallest_in = lgr_rdata;
            end
            if (lgr_rdata != pssl_pkg::NIL) begin
               sml_we    = 1'b1;
               sml_waddr = lgr_rdata[IW-1:0];
               sml_wdata = sml_rdata;
            end
            if (op_ff == pssl_pkg::OP_REKEY) begin
               key_in     = {keys_rdata[KW-1:HW], key_ff[HW-1:0]};
               keys_we    = 1'b1;
               keys_wdata = {keys_rdata[KW-1:HW], key_ff[HW-1:0]};
            end else begin
               in_use_in[s_ff[IW-1:0]]       = 1'b0;
               count_in                      = count_dec;
               fstk_we                       = 1'b1;
               fs_valid_in[count_dec[IW-1:0]] = 1'b1;
            end
         end
         pssl_pkg::CMD_INS_START: begin
            cur_in = smallest_ff;
            if (list_empty) begin
               smallest_in = s_ff;
               lgr_we      = 1'b1;
               sml_we      = 1'b1;
            end
         end
         pssl_pkg::CMD_INS_STEP: begin
            if (key_ff < keys_rdata) begin
               // goes in front of the current entry
               sm_in     = sml_rdata;
               lgr_we    = 1'b1;
               lgr_wdata = cur_ff;
               sml_we    = 1'b1;
               sml_waddr = cur_ff[IW-1:0];
               sml_wdata = s_ff;
            end else if (lgr_rdata == pssl_pkg::NIL) begin
               // append at the tail
               lgr_we    = 1'b1;
               lgr_waddr = cur_ff[IW-1:0];
               lgr_wdata = s_ff;
               sml_we    = 1'b1;
               sml_wdata = cur_ff;
            end else begin
               cur_in = lgr_rdata;
            end
         end
         pssl_pkg::CMD_INS_FIX: begin
            sml_we    = 1'b1;
            sml_wdata = sm_ff;
            if (sm_ff != pssl_pkg::NIL) begin
               lgr_we    = 1'b1;
               lgr_waddr = sm_ff[IW-1:0];
               lgr_wdata = s_ff;
            end else begin
               smallest_in = s_ff;
            end
         end
         pssl_pkg::CMD_INS_TAIL: begin
            lgr_we = 1'b1;
         end
         pssl_pkg::CMD_RESP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = res_status_ff;
               rsp_in.result_slot = res_slot_ff;
               rsp_in.last_of_run = 1'b1;
            end
         end
         pssl_pkg::CMD_WALK: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = pssl_pkg::STAT_OK;
               rsp_in.result_slot = cur_ff[SW-1:0];
               rsp_in.last_of_run = (lgr_rdata == pssl_pkg::NIL);
               cur_in             = lgr_rdata;
            end
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         smallest_ff  <= pssl_pkg::NIL;
         in_use_ff    <= '0;
         fs_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         smallest_ff  <= smallest_in;
         in_use_ff    <= in_use_in;
         fs_valid_ff  <= fs_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      h_ff          <= h_in;
      key_ff        <= key_in;
      s_ff          <= s_in;
      cur_ff        <= cur_in;
      sm_ff         <= sm_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sort keys
   pssl_ram #(.WIDTH(KW), .DEPTH(pssl_pkg::SLOT_COUNT)) u_keys (
      .clock   (clock),
      .wr_en   (keys_we),
      .wr_addr (keys_waddr),
      .wr_data (keys_wdata),
      .rd_addr (rd_addr),
      .rd_data (keys_rdata)
   );

   // links toward larger keys
   pssl_ram #(.WIDTH(LW), .DEPTH(pssl_pkg::SLOT_COUNT)) u_lgr (
      .clock   (clock),
      .wr_en   (lgr_we),
      .wr_addr (lgr_waddr),
      .wr_data (lgr_wdata),
      .rd_addr (rd_addr),
      .rd_data (lgr_rdata)
   );

   // links toward smaller keys
   pssl_ram #(.WIDTH(LW), .DEPTH(pssl_pkg::SLOT_COUNT)) u_sml (
      .clock   (clock),
      .wr_en   (sml_we),
      .wr_addr (sml_waddr),
      .wr_data (sml_wdata),
      .rd_addr (rd_addr),
      .rd_data (sml_rdata)
   );

   // free stack, entries never pushed read as their own index
   pssl_ram #(.WIDTH(SW), .DEPTH(pssl_pkg::SLOT_COUNT)) u_fstk (
      .clock   (clock),
      .wr_en   (fstk_we),
      .wr_addr (fstk_waddr),
      .wr_data (fstk_wdata),
      .rd_addr (count_ff[IW-1:0]),
      .rd_data (fstk_rdata)
   );

   // slot count never exceeds the pool
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pssl_pkg::SLOT_COUNT))
      else $error("slot count overflow");

   // between transactions the list head agrees with the count
   assert property (@(posedge clock) disable iff (reset)
      (cmd.code == pssl_pkg::CMD_LATCH) |-> (list_empty == (count_ff == '0)))
      else $error("list head and count disagree");

   // the number of slots marked in use tracks the count
   assert property (@(posedge clock) disable iff (reset)
      (cmd.code == pssl_pkg::CMD_LATCH) |-> ($countones(in_use_ff) == int'(count_ff)))
      else $error("in-use flags and count disagree");

endmodule
`default_nettype wire

// ===== sv/priority_sorted_slot_list_top.sv =====
`default_nettype none
// Sorted slot list: a pool of slots kept in ascending key order.
// Request channel req_valid/req_ready/req_data carries one command:
// alloc, release, rekey (new minor half) or walk.
// Response channel rsp_valid/rsp_ready/rsp_data returns status, slot and a
// last_of_run flag; alloc, release and rekey give one response, walk gives
// one per slot in use in ascending key order (or one "list empty").
// One transaction is worked on at a time. After decode an error goes
// straight to its response and release unlinks its slot; alloc pops a
// free slot and rekey unlinks its slot, then both insert it, into an
// empty list directly, else stepping up from the smallest entry until a
// larger key or the tail is reached. The insertion and the walk follow
// one link per cycle through the registered read port of the link
// memory, the walk only while the output register is free.
// A new request is taken once the previous one has loaded its last
// response, even while that response still waits in the output register.
// When the receiver stalls, the output register holds and the walk pauses.
// Reset empties the list and refills the free stack at once; no clearing
// pass is needed.
module priority_sorted_slot_list_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pssl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pssl_pkg::rsp_type      rsp_data
);

   pssl_pkg::cmd_type       cmd;
   pssl_pkg::dp_status_type sts;

   // sequencing
   pssl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // list storage and output register
   pssl_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/tb_priority_sorted_slot_list_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_priority_sorted_slot_list_top;

   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_COUNT = 250;
   localparam logic [6:0] NULL_LINK = 7'd64;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pssl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pssl_pkg::rsp_type rsp_data;

   priority_sorted_slot_list_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mirror of the slot pool
   logic [31:0] slot_key [64];
   logic [6:0]  next_larger [64];
   logic [6:0]  next_smaller [64];
   logic [5:0]  free_slots [64];
   logic        busy_slot [64];
   int          slots_used;
   logic [6:0]  list_head;

   pssl_pkg::rsp_type pending_rsp [$];
   int      mismatch_count = 0;
   int      rsp_seen = 0;
   int      req_sent = 0;
   int      idle_cycles = 0;
   int      walk_count = 0;
   int      full_count = 0;
   int      bad_handle_count = 0;
   bit      rx_hold_long = 1'b0;
   bit      no_idling = 1'b0;

   function automatic void pool_clear();
      for (int i = 0; i < 64; i++) begin
         slot_key[i] = '0;
         next_larger[i] = NULL_LINK;
         next_smaller[i] = NULL_LINK;
         free_slots[i] = 6'(i);
         busy_slot[i] = 1'b0;
      end
      slots_used = 0;
      list_head = NULL_LINK;
   endfunction

   function automatic void list_unlink(int s);
      logic [6:0] lg;
      logic [6:0] sm;
      lg = next_larger[s];
      sm = next_smaller[s];
      if (sm != NULL_LINK) next_larger[sm[5:0]] = lg;
      else list_head = lg;
      if (lg != NULL_LINK) next_smaller[lg[5:0]] = sm;
      next_larger[s] = NULL_LINK;
      next_smaller[s] = NULL_LINK;
   endfunction

   // sorted insert, newer entry after equal keys
   function automatic void list_insert(int s);
      int cur;
      logic [6:0] sm;
      if (list_head == NULL_LINK) begin
         list_head = 7'(s);
         next_larger[s] = NULL_LINK;
         next_smaller[s] = NULL_LINK;
         return;
      end
      cur = list_head[5:0];
      for (int n = 0; n < pssl_pkg::SLOT_COUNT; n++) begin
         if (slot_key[s] < slot_key[cur]) begin
            sm = next_smaller[cur];
            next_smaller[s] = sm;
            if (sm != NULL_LINK) next_larger[sm[5:0]] = 7'(s);
            else list_head = 7'(s);
            next_larger[s] = 7'(cur);
            next_smaller[cur] = 7'(s);
            return;
         end
         if (next_larger[cur] == NULL_LINK) begin
            next_larger[cur] = 7'(s);
            next_smaller[s] = 7'(cur);
            next_larger[s] = NULL_LINK;
            return;
         end
         cur = next_larger[cur][5:0];
      end
   endfunction

   function automatic void push_rsp(pssl_pkg::status_type st, int slot, bit last);
      pssl_pkg::rsp_type r;
      r.status = st;
      r.result_slot = 6'(slot);
      r.last_of_run = last;
      pending_rsp.push_back(r);
   endfunction

   // apply one command to the mirror and queue its responses
   function automatic void predict_command(pssl_pkg::req_type rq);
      int s;
      int h;
      int cur;
      bit ok;
      h = rq.slot_handle;
      ok = (h < pssl_pkg::SLOT_COUNT) && busy_slot[h];
      case (pssl_pkg::opcode_type'(rq.opcode))
         pssl_pkg::OP_ALLOC: begin
            if (slots_used >= pssl_pkg::SLOT_COUNT) begin
               full_count++;
               push_rsp(pssl_pkg::STAT_FULL, 0, 1'b1);
            end else begin
               s = free_slots[slots_used];
               slots_used++;
               busy_slot[s] = 1'b1;
               slot_key[s] = {rq.major_key, rq.minor_key};
               list_insert(s);
               push_rsp(pssl_pkg::STAT_OK, s, 1'b1);
            end
         end
         pssl_pkg::OP_RELEASE: begin
            if (slots_used == 0) push_rsp(pssl_pkg::STAT_IGNORED, 0, 1'b1);
            else if (!ok) begin
               bad_handle_count++;
               push_rsp(pssl_pkg::STAT_BAD_HANDLE, 0, 1'b1);
            end else begin
               list_unlink(h);
               busy_slot[h] = 1'b0;
               slots_used--;
               free_slots[slots_used] = 6'(h);
               push_rsp(pssl_pkg::STAT_OK, 0, 1'b1);
            end
         end
         pssl_pkg::OP_REKEY: begin
            if (!ok) begin
               bad_handle_count++;
               push_rsp(pssl_pkg::STAT_BAD_HANDLE, 0, 1'b1);
            end else begin
               list_unlink(h);
               slot_key[h][15:0] = rq.minor_key;
               list_insert(h);
               push_rsp(pssl_pkg::STAT_OK, 0, 1'b1);
            end
         end
         default: begin
            walk_count++;
            if (list_head == NULL_LINK) push_rsp(pssl_pkg::STAT_EMPTY, 0, 1'b1);
            else begin
               cur = list_head;
               while (cur != NULL_LINK) begin
                  push_rsp(pssl_pkg::STAT_OK, cur[5:0],
                           next_larger[cur[5:0]] == NULL_LINK);
                  cur = next_larger[cur[5:0]];
               end
            end
         end
      endcase
   endfunction

   // response checking at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %p", rsp_data);
         end else begin
            pssl_pkg::rsp_type exp_rsp;
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p, got %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout waiting for a transaction");
         $display("[priority_sorted_slot_list_top] ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts, or a long hold-off when asked
   initial begin
      int gap;
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold_long) begin
            rsp_ready <= 1'b0;
            hold = 0;
            while (hold < 600) begin
               @(negedge clock);
               hold++;
            end
            rx_hold_long = 1'b0;
         end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // send one command and hold it until accepted
   task automatic send_command(pssl_pkg::req_type rq);
      if (!no_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_command(rq);
      req_sent++;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic pssl_pkg::req_type make_command(pssl_pkg::opcode_type op, int h,
                                                      int mj, int mn);
      pssl_pkg::req_type rq;
      rq.opcode = op;
      rq.slot_handle = 6'(h);
      rq.major_key = 16'(mj);
      rq.minor_key = 16'(mn);
      return rq;
   endfunction

   // directed table: command plus a typed expectation where obvious
   typedef struct {
      pssl_pkg::req_type cmd;
      bit                has_exp;
      pssl_pkg::rsp_type exp;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void add_row(pssl_pkg::opcode_type op, int h, int mj, int mn,
                                   bit has_exp, pssl_pkg::status_type st, int slot);
      dir_row_type r;
      r.cmd = make_command(op, h, mj, mn);
      r.has_exp = has_exp;
      r.exp.status = st;
      r.exp.result_slot = 6'(slot);
      r.exp.last_of_run = 1'b1;
      dir_rows.push_back(r);
   endfunction

   function automatic pssl_pkg::req_type random_command();
      int pick;
      int h;
      pick = $urandom_range(0, 99);
      h = $urandom_range(0, 63);
      // mostly handles that are in use, so rekey and release do real work
      if ($urandom_range(0, 4) != 0 && slots_used > 0) begin
         int tries;
         tries = 0;
         while (!busy_slot[h] && tries < 200) begin
            h = $urandom_range(0, 63);
            tries++;
         end
      end
      if (pick < 40) return make_command(pssl_pkg::OP_ALLOC, h,
                                         $urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 65535) : $urandom_range(0, 3),
                                         $urandom_range(0, 65535));
      if (pick < 65) return make_command(pssl_pkg::OP_RELEASE, h, $urandom, $urandom);
      if (pick < 88) return make_command(pssl_pkg::OP_REKEY, h, $urandom,
                                         $urandom_range(0, 1) ? $urandom_range(0, 65535) :
                                         $urandom_range(0, 3));
      return make_command(pssl_pkg::OP_WALK, h, $urandom, $urandom);
   endfunction

   initial begin
      pool_clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, equal keys, rekey, walk
      add_row(pssl_pkg::OP_WALK, 0, 0, 0, 1, pssl_pkg::STAT_EMPTY, 0);
      add_row(pssl_pkg::OP_RELEASE, 5, 0, 0, 1, pssl_pkg::STAT_IGNORED, 0);
      add_row(pssl_pkg::OP_REKEY, 0, 0, 0, 1, pssl_pkg::STAT_BAD_HANDLE, 0);
      add_row(pssl_pkg::OP_ALLOC, 0, 16'hFFFF, 16'hFFFF, 1, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_ALLOC, 63, 0, 0, 1, pssl_pkg::STAT_OK, 1);
      add_row(pssl_pkg::OP_ALLOC, 0, 16'h1234, 16'h8000, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_ALLOC, 0, 16'h1234, 16'h8000, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_WALK, 0, 0, 0, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_RELEASE, 63, 0, 0, 1, pssl_pkg::STAT_BAD_HANDLE, 0);
      add_row(pssl_pkg::OP_REKEY, 40, 0, 0, 1, pssl_pkg::STAT_BAD_HANDLE, 0);
      add_row(pssl_pkg::OP_REKEY, 0, 0, 16'h0000, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_REKEY, 1, 0, 16'hFFFF, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_WALK, 0, 0, 0, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_RELEASE, 2, 0, 0, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_ALLOC, 0, 16'h5555, 16'hAAAA, 0, pssl_pkg::STAT_OK, 0);
      add_row(pssl_pkg::OP_WALK, 0, 0, 0, 0, pssl_pkg::STAT_OK, 0);
      foreach (dir_rows[i]) begin
         send_command(dir_rows[i].cmd);
         if (dir_rows[i].has_exp) begin
            // table value must agree with the mirror's prediction
            if (pending_rsp[$] !== dir_rows[i].exp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("table row %0d: expected %p, mirror %p",
                           i, dir_rows[i].exp, pending_rsp[$]);
            end
         end
      end

      // fill the pool to the brim, hit pool full, walk all 64
      while (slots_used < pssl_pkg::SLOT_COUNT)
         send_command(make_command(pssl_pkg::OP_ALLOC, 0, $urandom_range(0, 7), $urandom));
      send_command(make_command(pssl_pkg::OP_ALLOC, 0, 0, 0));
      send_command(make_command(pssl_pkg::OP_WALK, 0, 0, 0));

      // long receiver hold-off while the sender keeps offering
      rx_hold_long = 1'b1;
      for (int i = 0; i < 20; i++) send_command(random_command());

      // sender pauses until everything has come back
      drain_responses();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT - 60) no_idling = 1'b1;
         send_command(random_command());
      end

      drain_responses();
      $display("sent %0d commands, %0d responses, %0d walks, %0d pool full, %0d bad handles",
               req_sent, rsp_seen, walk_count, full_count, bad_handle_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("[priority_sorted_slot_list_top] OK");
      else
         $display("[priority_sorted_slot_list_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
